// File: hw/rtl/pending_event_queue_core_defines.svh
// assertion macros used by the pending event queue sequencer
`ifndef PENDING_EVENT_QUEUE_CORE_DEFINES_SVH
`define PENDING_EVENT_QUEUE_CORE_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define PEQ_ASSERT_CR(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the usual clk_i / rst_ni pair
`define PEQ_ASSERT(label, prop, msg) \
  `PEQ_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// File: hw/rtl/peq_pkg.sv
// types and constants of the pending event queue
`default_nettype none

package peq_pkg;

  localparam int unsigned NumEvents = 32;
  localparam int unsigned EvtW      = $clog2(NumEvents);

  localparam logic [1:0] CmdEnable  = 2'd0;
  localparam logic [1:0] CmdDisable = 2'd1;
  localparam logic [1:0] CmdSet     = 2'd2;
  localparam logic [1:0] CmdPop     = 2'd3;

  typedef struct packed {
    logic [1:0]      command;
    logic [EvtW-1:0] event_id;
  } in_item_t;

  typedef struct packed {
    logic            ok;
    logic            popped_valid;
    logic [EvtW-1:0] popped_event;
    logic            event_enabled;
  } out_item_t;

  typedef struct packed {
    logic            rd_en;
    logic [EvtW-1:0] rd_addr;
    logic            wr_en;
    logic [EvtW-1:0] wr_addr;
    logic [EvtW-1:0] wr_data;
  } link_req_t;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StExec   = 6'b000010,
    StHead   = 6'b000100,
    StWalk   = 6'b001000,
    StUnlink = 6'b010000,
    StDone   = 6'b100000
  } seq_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/peq_link_ram.sv
// single-port-write, single-port-read link memory with registered read data
`default_nettype none

module peq_link_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/peq_seq.sv
// command sequencer: event flags, queue pointers and the unlink walk
`default_nettype none
`include "pending_event_queue_core_defines.svh"

module peq_seq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire peq_pkg::in_item_t              in_data_i,
  output logic                                in_ready_o,
  input  wire logic                           res_ready_i,
  output logic                                res_valid_o,
  output peq_pkg::out_item_t                  res_o,
  output peq_pkg::link_req_t                  link_req_o,
  input  wire logic [peq_pkg::EvtW-1:0]       link_rdata_i
);

  localparam logic [peq_pkg::EvtW-1:0] CntLast = peq_pkg::EvtW'(peq_pkg::NumEvents - 1);

  peq_pkg::seq_state_e state_q, state_d;
  logic [1:0]                     cmd_q, cmd_d;
  logic [peq_pkg::EvtW-1:0]       id_q, id_d;
  logic [peq_pkg::NumEvents-1:0]  en_q, en_d;
  logic [peq_pkg::NumEvents-1:0]  pend_q, pend_d;
  logic [peq_pkg::EvtW-1:0]       head_q, head_d;
  logic [peq_pkg::EvtW-1:0]       tail_q, tail_d;
  logic                           nonempty_q, nonempty_d;
  logic [peq_pkg::EvtW-1:0]       cur_q, cur_d;
  logic [peq_pkg::EvtW-1:0]       cnt_q, cnt_d;
  peq_pkg::out_item_t             res_q, res_d;
  logic                           accept;

  assign in_ready_o  = (state_q == peq_pkg::StIdle) ||
                       ((state_q == peq_pkg::StDone) && res_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == peq_pkg::StDone);
  assign res_o       = res_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    id_d       = id_q;
    en_d       = en_q;
    pend_d     = pend_q;
    head_d     = head_q;
    tail_d     = tail_q;
    nonempty_d = nonempty_q;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    link_req_o = '0;

    case (state_q)
      peq_pkg::StIdle: begin
        if (accept) begin
          cmd_d   = in_data_i.command;
          id_d    = in_data_i.event_id;
          state_d = peq_pkg::StExec;
        end
      end

      peq_pkg::StExec: begin
        res_d   = '0;
        state_d = peq_pkg::StDone;
        case (cmd_q)
          peq_pkg::CmdEnable: begin
            if (!en_q[id_q]) begin
              en_d[id_q] = 1'b1;
              res_d.ok   = 1'b1;
            end
            res_d.event_enabled = 1'b1;
          end
          peq_pkg::CmdDisable: begin
            if (en_q[id_q]) begin
              en_d[id_q]   = 1'b0;
              pend_d[id_q] = 1'b0;
              if (pend_q[id_q] && nonempty_q) begin
                if (head_q == id_q) begin
                  if (tail_q == id_q) begin
                    nonempty_d = 1'b0;
                  end else begin
                    link_req_o.rd_en   = 1'b1;
                    link_req_o.rd_addr = id_q;
                    state_d            = peq_pkg::StHead;
                  end
                end else begin
                  cur_d = head_q;
                  cnt_d = '0;
                  if (head_q != tail_q) begin
                    link_req_o.rd_en   = 1'b1;
                    link_req_o.rd_addr = head_q;
                    state_d            = peq_pkg::StWalk;
                  end
                end
              end
            end
          end
          peq_pkg::CmdSet: begin
            if (en_q[id_q] && !pend_q[id_q]) begin
              pend_d[id_q] = 1'b1;
              if (!nonempty_q) begin
                head_d     = id_q;
                nonempty_d = 1'b1;
              end else begin
                link_req_o.wr_en   = 1'b1;
                link_req_o.wr_addr = tail_q;
                link_req_o.wr_data = id_q;
              end
              tail_d = id_q;
            end
            res_d.event_enabled = en_q[id_q];
          end
          default: begin
            // pop of the oldest pending event
            if (nonempty_q) begin
              pend_d[head_q]      = 1'b0;
              res_d.ok            = 1'b1;
              res_d.popped_valid  = 1'b1;
              res_d.popped_event  = head_q;
              res_d.event_enabled = en_q[head_q];
              if (head_q == tail_q) begin
                nonempty_d = 1'b0;
              end else begin
                link_req_o.rd_en   = 1'b1;
                link_req_o.rd_addr = head_q;
                state_d            = peq_pkg::StHead;
              end
            end
          end
        endcase
      end

      peq_pkg::StHead: begin
        head_d  = link_rdata_i;
        state_d = peq_pkg::StDone;
      end

      peq_pkg::StWalk: begin
        // link_rdata_i holds the successor of cur_q
        if (link_rdata_i == id_q) begin
          link_req_o.rd_en   = 1'b1;
          link_req_o.rd_addr = id_q;
          state_d            = peq_pkg::StUnlink;
        end else begin
          cur_d = link_rdata_i;
          cnt_d = cnt_q + 1'b1;
          if ((link_rdata_i == tail_q) || (cnt_q == CntLast)) begin
            state_d = peq_pkg::StDone;
          end else begin
            link_req_o.rd_en   = 1'b1;
            link_req_o.rd_addr = link_rdata_i;
          end
        end
      end

      peq_pkg::StUnlink: begin
        // bypass the removed event: predecessor takes its successor
        link_req_o.wr_en   = 1'b1;
        link_req_o.wr_addr = cur_q;
        link_req_o.wr_data = link_rdata_i;
        if (tail_q == id_q) begin
          tail_d = cur_q;
        end
        state_d = peq_pkg::StDone;
      end

      peq_pkg::StDone: begin
        if (res_ready_i) begin
          if (accept) begin
            cmd_d   = in_data_i.command;
            id_d    = in_data_i.event_id;
            state_d = peq_pkg::StExec;
          end else begin
            state_d = peq_pkg::StIdle;
          end
        end
      end

      default: begin
        state_d = peq_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= peq_pkg::StIdle;
      en_q       <= '0;
      pend_q     <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      nonempty_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      en_q       <= en_d;
      pend_q     <= pend_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      nonempty_q <= nonempty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    id_q  <= id_d;
    cur_q <= cur_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  `PEQ_ASSERT(a_ends_pending,
    (nonempty_q && (state_q == peq_pkg::StIdle || state_q == peq_pkg::StDone)) |->
      (pend_q[head_q] && pend_q[tail_q]),
    "queue head or tail not marked pending")

  `PEQ_ASSERT(a_empty_none_pending,
    (!nonempty_q && (state_q == peq_pkg::StIdle || state_q == peq_pkg::StDone)) |->
      (pend_q == '0),
    "pending event left while queue is empty")

  `PEQ_ASSERT(a_pending_enabled,
    (state_q == peq_pkg::StIdle || state_q == peq_pkg::StDone) |-> ((pend_q & ~en_q) == '0),
    "pending event that is not enabled")

  `PEQ_ASSERT(a_pop_only_on_pop,
    (res_valid_o && res_o.popped_valid) |-> (cmd_q == peq_pkg::CmdPop && res_o.ok),
    "popped event reported outside a successful pop")

endmodule

`default_nettype wire

// File: hw/rtl/pending_event_queue_core.sv
// Pending event queue: keeps NumEvents events, each enabled or not, and links pending
// events into an arrival-ordered queue in a small link memory. Commands are enable,
// disable, set pending (deduplicated) and pop oldest; each gives exactly one result.
// Work per command is set by link memory round trips: enable, set, a disable of an
// event that is not queued, and a pop or disable of the only queued event need none;
// any other pop or disable of the queue head reads the new head from the link memory;
// a disable deeper in the queue walks the links at one read per cycle.
// A finished result sits in an output register, so the next command can be accepted
// while the previous result waits.
`default_nettype none

module pending_event_queue_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire peq_pkg::in_item_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output peq_pkg::out_item_t  out_data_o
);

  peq_pkg::link_req_t       link_req;
  logic [peq_pkg::EvtW-1:0] link_rdata;
  logic                     res_valid;
  logic                     res_ready;
  peq_pkg::out_item_t       res;
  logic                     out_valid_q, out_valid_d;
  peq_pkg::out_item_t       out_data_q;

  // output slot frees up when empty or when its transfer completes this cycle
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !out_ready_i);

  peq_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_ready_o   (in_ready_o),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .link_req_o   (link_req),
    .link_rdata_i (link_rdata)
  );

  peq_link_ram #(
    .Width (peq_pkg::EvtW),
    .Depth (peq_pkg::NumEvents)
  ) u_link_ram (
    .clk_i     (clk_i),
    .rd_en_i   (link_req.rd_en),
    .rd_addr_i (link_req.rd_addr),
    .rd_data_o (link_rdata),
    .wr_en_i   (link_req.wr_en),
    .wr_addr_i (link_req.wr_addr),
    .wr_data_i (link_req.wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: dv/pending_event_queue_core_tb.sv
// self-checking testbench of the pending event queue core
`default_nettype none

module pending_event_queue_core_tb;

  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned SettleCycles = peq_pkg::NumEvents + 8;
  localparam int unsigned PhaseItems  = 160;
  localparam int unsigned MaxPrinted  = 40;

  // shadow of the event table and the linked queue, plus the results it predicts
  class event_queue_scoreboard;
    bit [peq_pkg::NumEvents-1:0] enabled;
    bit [peq_pkg::NumEvents-1:0] pending;
    bit [peq_pkg::EvtW-1:0]      link_mem [peq_pkg::NumEvents];
    bit [peq_pkg::EvtW-1:0]      head;
    bit [peq_pkg::EvtW-1:0]      tail;
    bit                          nonempty;
    peq_pkg::out_item_t          expected_results [$];
    int unsigned                 mismatches;
    int unsigned                 results_seen;

    task report(string msg);
      if (mismatches < MaxPrinted) begin
        $display("mismatch at result %0d: %s", results_seen, msg);
      end
      mismatches++;
    endtask

    // unlink e from the queue, walking to its predecessor if it is not the head
    function void unlink_event(bit [peq_pkg::EvtW-1:0] e);
      bit [peq_pkg::EvtW-1:0] cur;
      bit [peq_pkg::EvtW-1:0] nxt;
      if (!nonempty) return;
      if (head == e) begin
        if (tail == e) nonempty = 1'b0;
        else head = link_mem[e];
        return;
      end
      cur = head;
      for (int n = 0; n < peq_pkg::NumEvents; n++) begin
        if (cur == tail) return;
        nxt = link_mem[cur];
        if (nxt == e) begin
          link_mem[cur] = link_mem[e];
          if (tail == e) tail = cur;
          return;
        end
        cur = nxt;
      end
    endfunction

    function peq_pkg::out_item_t predict_result(peq_pkg::in_item_t cmd);
      peq_pkg::out_item_t     res;
      bit [peq_pkg::EvtW-1:0] id;
      bit [peq_pkg::EvtW-1:0] e;
      res = '0;
      id  = cmd.event_id;
      case (cmd.command)
        peq_pkg::CmdPop: begin
          if (nonempty) begin
            e = head;
            if (head == tail) nonempty = 1'b0;
            else head = link_mem[e];
            pending[e]         = 1'b0;
            res.ok             = 1'b1;
            res.popped_valid   = 1'b1;
            res.popped_event   = e;
            res.event_enabled  = enabled[e];
          end
        end
        peq_pkg::CmdEnable: begin
          if (!enabled[id]) begin
            enabled[id] = 1'b1;
            res.ok      = 1'b1;
          end
        end
        peq_pkg::CmdDisable: begin
          if (enabled[id]) begin
            if (pending[id]) unlink_event(id);
            pending[id] = 1'b0;
            enabled[id] = 1'b0;
          end
        end
        default: begin
          if (enabled[id] && !pending[id]) begin
            pending[id] = 1'b1;
            if (!nonempty) begin
              head     = id;
              tail     = id;
              nonempty = 1'b1;
            end else begin
              link_mem[tail] = id;
              tail           = id;
            end
          end
        end
      endcase
      if (cmd.command != peq_pkg::CmdPop) res.event_enabled = enabled[id];
      return res;
    endfunction

    function void note_command(peq_pkg::in_item_t cmd);
      expected_results.push_back(predict_result(cmd));
    endfunction

    task check_result(peq_pkg::out_item_t got);
      peq_pkg::out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing expected (ok=%b pv=%b ev=%0d en=%b)",
                         got.ok, got.popped_valid, got.popped_event, got.event_enabled));
        return;
      end
      want = expected_results.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok got %b want %b", got.ok, want.ok));
      if (got.popped_valid !== want.popped_valid)
        report($sformatf("popped_valid got %b want %b", got.popped_valid, want.popped_valid));
      if (got.popped_event !== want.popped_event)
        report($sformatf("popped_event got %0d want %0d", got.popped_event, want.popped_event));
      if (got.event_enabled !== want.event_enabled)
        report($sformatf("event_enabled got %b want %b", got.event_enabled,
                         want.event_enabled));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  peq_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  peq_pkg::out_item_t out_data;

  event_queue_scoreboard board = new;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned stall_cycles  = 0;
  bit          hold_request  = 1'b0;

  pending_event_queue_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) board.note_command(in_data);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) board.check_result(out_data);
  end

  // watchdog: cycles in a row with no transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("pending_event_queue_core_tb failed");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_command(logic [1:0] cmd, logic [peq_pkg::EvtW-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid         <= 1'b1;
    in_data.command  <= cmd;
    in_data.event_id <= id;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (board.expected_results.size() != 0);
  endtask

  task automatic send_random_command();
    logic [1:0]               cmd;
    logic [peq_pkg::EvtW-1:0] id;
    int unsigned              roll;
    roll = $urandom_range(99);
    if (roll < 20) cmd = peq_pkg::CmdEnable;
    else if (roll < 35) cmd = peq_pkg::CmdDisable;
    else if (roll < 70) cmd = peq_pkg::CmdSet;
    else cmd = peq_pkg::CmdPop;
    // a narrow id range half the time, so duplicates and deep walks show up
    if ($urandom_range(1) == 1) id = peq_pkg::EvtW'($urandom_range(7));
    else id = peq_pkg::EvtW'($urandom_range(peq_pkg::NumEvents - 1));
    send_command(cmd, id);
  endtask

  // enable a set of events, queue them, disable some anywhere in the queue, then drain
  task automatic run_queue_burst(int unsigned count);
    logic [peq_pkg::EvtW-1:0]    ids [$];
    logic [peq_pkg::EvtW-1:0]    pick;
    bit [peq_pkg::NumEvents-1:0] taken;
    taken = '0;
    while (ids.size() < count) begin
      pick = peq_pkg::EvtW'($urandom_range(peq_pkg::NumEvents - 1));
      if (!taken[pick]) begin
        taken[pick] = 1'b1;
        ids.push_back(pick);
      end
    end
    foreach (ids[i]) send_command(peq_pkg::CmdEnable, ids[i]);
    ids.shuffle();
    foreach (ids[i]) begin
      send_command(peq_pkg::CmdSet, ids[i]);
      if ($urandom_range(99) < 20) send_command(peq_pkg::CmdSet, ids[$urandom_range(i)]);
      if ($urandom_range(99) < 10) send_command(peq_pkg::CmdPop, '0);
    end
    repeat (count / 3 + 1) begin
      pick = ids[$urandom_range(ids.size() - 1)];
      send_command(peq_pkg::CmdDisable, pick);
      if ($urandom_range(1) == 1) begin
        send_command(peq_pkg::CmdEnable, pick);
        send_command(peq_pkg::CmdSet, pick);
      end
    end
    repeat (count + 1) begin
      send_command(peq_pkg::CmdPop,
                   peq_pkg::EvtW'($urandom_range(peq_pkg::NumEvents - 1)));
    end
  endtask

  task automatic run_phase(int unsigned s_pct, int unsigned r_pct, bit with_holdoff);
    int unsigned stop_at;
    bit          drained_mid;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at       = items_sent + PhaseItems;
    drained_mid   = 1'b0;
    wait_for_drain();
    if (with_holdoff) begin
      // sender keeps offering while the receiver is held off
      hold_request = 1'b1;
      run_queue_burst(peq_pkg::NumEvents);
    end
    while (items_sent < stop_at) begin
      if (!drained_mid && items_sent > stop_at - PhaseItems / 2) begin
        drained_mid = 1'b1;
        wait_for_drain();
      end
      if ($urandom_range(99) < 60) begin
        run_queue_burst($urandom_range(3, 10));
      end else begin
        repeat ($urandom_range(1, 8)) send_random_command();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(peq_pkg::CmdPop, 5'd17);
    send_command(peq_pkg::CmdEnable, 5'd0);
    send_command(peq_pkg::CmdEnable, 5'd0);
    send_command(peq_pkg::CmdEnable, 5'd31);
    send_command(peq_pkg::CmdSet, 5'd5);
    send_command(peq_pkg::CmdSet, 5'd0);
    send_command(peq_pkg::CmdSet, 5'd0);
    send_command(peq_pkg::CmdSet, 5'd31);
    send_command(peq_pkg::CmdPop, 5'd0);
    send_command(peq_pkg::CmdPop, 5'd31);
    send_command(peq_pkg::CmdPop, 5'd0);
    send_command(peq_pkg::CmdEnable, 5'd7);
    send_command(peq_pkg::CmdEnable, 5'd12);
    send_command(peq_pkg::CmdSet, 5'd7);
    send_command(peq_pkg::CmdSet, 5'd12);
    send_command(peq_pkg::CmdSet, 5'd31);
    send_command(peq_pkg::CmdSet, 5'd0);
    // middle of the queue, then the tail, then the head
    send_command(peq_pkg::CmdDisable, 5'd31);
    send_command(peq_pkg::CmdDisable, 5'd0);
    send_command(peq_pkg::CmdDisable, 5'd7);
    send_command(peq_pkg::CmdEnable, 5'd7);
    send_command(peq_pkg::CmdSet, 5'd7);
    send_command(peq_pkg::CmdDisable, 5'd12);
    send_command(peq_pkg::CmdDisable, 5'd7);
    send_command(peq_pkg::CmdDisable, 5'd7);
    send_command(peq_pkg::CmdPop, 5'd0);

    run_phase(17, 72, 1'b0);
    run_phase(72, 17, 1'b0);
    run_phase(0, 0, 1'b1);

    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("pending_event_queue_core_tb passed");
    end else begin
      $display("pending_event_queue_core_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/peq_pkg.sv
hw/rtl/peq_link_ram.sv
hw/rtl/peq_seq.sv
hw/rtl/pending_event_queue_core.sv
dv/pending_event_queue_core_tb.sv
